// File: rtl/assert_macros.svh
// Assertion helpers. Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/tlp_pkg.sv
package tlp_pkg;

  typedef enum logic [2:0] {
    PH_EXPECT_AT   = 3'd0,
    PH_STAMP_FIRST = 3'd1,
    PH_STAMP       = 3'd2,
    PH_BETWEEN     = 3'd3,
    PH_NAME        = 3'd4,
    PH_LINE_END    = 3'd5,
    PH_HALTED      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_SEP   = 2'd0,
    ROLE_AT    = 2'd1,
    ROLE_DIGIT = 2'd2,
    ROLE_NAME  = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NO_AT     = 3'd1,
    ERR_NONDIGIT  = 3'd2,
    ERR_EMPTY     = 3'd3,
    ERR_NAME_HEAD = 3'd4,
    ERR_NAME_CHAR = 3'd5,
    ERR_HALTED    = 3'd6
  } err_t;

  typedef struct packed {
    role_t role;
    logic  event_start;
    logic  name_first;
    logic  done;
    err_t  err;
  } tlp_result_t;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= CH_UC_A) && (b <= CH_UC_Z)) || ((b >= CH_LC_A) && (b <= CH_LC_Z));
  endfunction

  function automatic logic is_line_end(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// File: rtl/timestamped_event_line_parser.sv
// Channel  | ports                                          | direction
// input    | in_valid, in_stall, in_data_byte, in_end_of_input | byte stream in
// result   | out_valid, out_stall, out_byte_out, out_role,  | one result per byte
//          | out_event_start, out_name_first, out_input_done_ok, out_error_code |
//
// One byte per cycle when not stalled; two registers (input register, result register).
// The 3-bit parse phase advances as a byte moves from the input register to the result
// register, so its update loop is the only feedback path.
// Synchronous active-low reset empties both registers and returns to expecting '@'.
// out_stall holds the result register; the input register keeps accepting while the
// result slot is free or being taken in the same cycle.

module timestamped_event_line_parser import tlp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic [1:0] out_role,
  output logic       out_event_start,
  output logic       out_name_first,
  output logic       out_input_done_ok,
  output logic [2:0] out_error_code
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  tlp_result_t out_res_r;
  tlp_result_t res;
  logic        out_free;
  logic        step;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  tlp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (s1_byte_r),
    .end_of_input (s1_last_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= s1_byte_r;
      out_res_r  <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_out      = out_byte_r;
  assign out_role          = out_res_r.role;
  assign out_event_start   = out_res_r.event_start;
  assign out_name_first    = out_res_r.name_first;
  assign out_input_done_ok = out_res_r.done;
  assign out_error_code    = out_res_r.err;

endmodule

// File: rtl/tlp_parse.sv
`include "assert_macros.svh"

module tlp_parse import tlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  output tlp_result_t res
);

  phase_t phase_r, phase_nxt;
  phase_t next_raw;
  err_t   err_raw, err_fin;
  logic   done;
  role_t  role_raw;
  logic   start_raw, first_raw;
  logic   b_sep, b_le, b_dig, b_let;

  assign b_sep = (data_byte == CH_SPACE);
  assign b_le  = is_line_end(data_byte);
  assign b_dig = is_digit(data_byte);
  assign b_let = is_letter(data_byte);

  // next state and error class of this byte
  always_comb begin
    next_raw = phase_r;
    err_raw  = ERR_OK;
    case (phase_r)
      PH_EXPECT_AT, PH_LINE_END: begin
        if (data_byte == CH_AT) next_raw = PH_STAMP_FIRST;
        else if (phase_r == PH_LINE_END && b_le) next_raw = PH_LINE_END;
        else err_raw = ERR_NO_AT;
      end
      PH_STAMP_FIRST, PH_STAMP: begin
        if (b_sep || b_le) begin
          if (phase_r == PH_STAMP_FIRST) err_raw = ERR_EMPTY;
          else next_raw = b_sep ? PH_BETWEEN : PH_LINE_END;
        end else if (b_dig) begin
          next_raw = PH_STAMP;
        end else begin
          err_raw = ERR_NONDIGIT;
        end
      end
      PH_BETWEEN, PH_NAME: begin
        if (b_sep) next_raw = PH_BETWEEN;
        else if (b_le) next_raw = PH_LINE_END;
        else if (phase_r == PH_BETWEEN) begin
          if (b_let) next_raw = PH_NAME;
          else err_raw = ERR_NAME_HEAD;
        end else if (!(b_let || b_dig)) begin
          err_raw = ERR_NAME_CHAR;
        end
      end
      default: begin
        err_raw  = ERR_HALTED;
        next_raw = PH_HALTED;
      end
    endcase

    // end of input: a stamp with no digit yet is empty, any other error-free byte closes cleanly
    err_fin = err_raw;
    done    = 1'b0;
    if (err_raw == ERR_OK && end_of_input) begin
      if (next_raw == PH_STAMP_FIRST) err_fin = ERR_EMPTY;
      else done = 1'b1;
    end

    if (err_fin != ERR_OK) phase_nxt = PH_HALTED;
    else if (done) phase_nxt = PH_EXPECT_AT;
    else phase_nxt = next_raw;
  end

  // byte role and marks
  always_comb begin
    role_raw  = ROLE_SEP;
    start_raw = 1'b0;
    first_raw = 1'b0;
    case (phase_r)
      PH_EXPECT_AT, PH_LINE_END: begin
        if (data_byte == CH_AT) begin
          role_raw  = ROLE_AT;
          start_raw = 1'b1;
        end
      end
      PH_STAMP_FIRST, PH_STAMP: begin
        if (b_dig && !b_sep) role_raw = ROLE_DIGIT;
      end
      PH_BETWEEN: begin
        if (b_let) begin
          role_raw  = ROLE_NAME;
          first_raw = 1'b1;
        end
      end
      PH_NAME: begin
        if (b_let || b_dig) role_raw = ROLE_NAME;
      end
      default: begin
        role_raw = ROLE_SEP;
      end
    endcase

    res.err  = err_fin;
    res.done = done && (err_fin == ERR_OK);
    // an at sign that ends the input keeps its marks despite the empty stamp
    if (err_fin == ERR_OK || (err_fin == ERR_EMPTY && role_raw == ROLE_AT)) begin
      res.role        = role_raw;
      res.event_start = start_raw;
      res.name_first  = first_raw;
    end else begin
      res.role        = ROLE_SEP;
      res.event_start = 1'b0;
      res.name_first  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EXPECT_AT;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  `ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALTED, phase_r == PH_HALTED)
  `ASSERT_NEXT(a_err_halts, step && res.err != ERR_OK, phase_r == PH_HALTED)
  `ASSERT_NEXT(a_done_rearms, step && res.done, phase_r == PH_EXPECT_AT)
  `ASSERT_ALWAYS(a_start_is_at, !step || !res.event_start || res.role == ROLE_AT)

endmodule
